// File: hdl/tpc_pkg.sv
// Shared types, constants and the end-around-carry adder for the checksum block.
package tpc_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [15:0] COUNT_MAX  = 16'hffff;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;

    // One classified request handed from the front end to the accumulator.
    typedef struct packed {
        logic [15:0] word;      // data word to add, zero when none completes
        logic [15:0] addr_sum;  // pseudo-header address sum, zero when unused
        logic        first;
        logic        last;
        logic        pseudo;
    } t_tpc_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_tpc_qstat;

    // Ones'-complement add of two 16-bit words with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// File: hdl/tpc_front.sv
// Front end: accepts byte requests, pairs bytes into words, pre-sums the addresses.
module tpc_front
    import tpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // data_byte[7:0], src_addr[39:8], dst_addr[71:40]
    input  logic       s_axis_tlast,
    input  logic [1:0] s_axis_tuser,    // first[0], use_pseudo[1]
    input  t_tpc_qstat i_qstat,
    output logic       o_push,
    output t_tpc_cmd   o_cmd
);

    logic        r_valid, n_valid;
    logic        r_odd, n_odd;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_word, r_src_sum, r_dst_sum;
    logic        r_first, r_last, r_pseudo;

    logic        w_accept;
    logic [7:0]  w_byte;
    logic        w_first, w_use;
    logic [31:0] w_src, w_dst;
    logic        w_eff_odd;
    logic [15:0] w_word;

    assign w_byte  = s_axis_tdata[7:0];
    assign w_src   = s_axis_tdata[39:8];
    assign w_dst   = s_axis_tdata[71:40];
    assign w_first = s_axis_tuser[0];
    assign w_use   = s_axis_tuser[1];

    assign o_push        = r_valid && !i_qstat.full;
    assign s_axis_tready = !r_valid || !i_qstat.full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // first restarts pairing before this byte is taken
    assign w_eff_odd = r_odd && !w_first;

    always_comb begin
        n_odd  = r_odd;
        n_held = r_held;
        w_word = 16'd0;
        if (w_eff_odd) begin
            w_word = {r_held, w_byte};
            n_odd  = 1'b0;
        end else begin
            n_held = w_byte;
            n_odd  = !s_axis_tlast;
            if (s_axis_tlast) begin
                w_word = {w_byte, 8'h00};
            end
        end
        if (!w_accept) begin
            n_odd  = r_odd;
            n_held = r_held;
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_odd   <= 1'b0;
            r_held  <= 8'd0;
        end else begin
            r_valid <= n_valid;
            r_odd   <= n_odd;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word    <= w_word;
            r_src_sum <= oc_add(w_src[31:16], w_src[15:0]);
            r_dst_sum <= oc_add(w_dst[31:16], w_dst[15:0]);
            r_first   <= w_first;
            r_last    <= s_axis_tlast;
            r_pseudo  <= w_first && w_use;
        end
    end

    always_comb begin
        o_cmd.word     = r_word;
        o_cmd.addr_sum = r_pseudo ? oc_add(r_src_sum, r_dst_sum) : 16'd0;
        o_cmd.first    = r_first;
        o_cmd.last     = r_last;
        o_cmd.pseudo   = r_pseudo;
    end

endmodule

// File: hdl/tpc_queue.sv
// Small request queue between front end and accumulator, first word falls through.
module tpc_queue
    import tpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_tpc_cmd   i_cmd,
    input  logic       i_pop,
    output t_tpc_cmd   o_cmd,
    output t_tpc_qstat o_qstat
);

    t_tpc_cmd            r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, n_wptr;
    logic [QPTR_W-1:0]   r_rptr, n_rptr;
    logic [QCNT_W-1:0]   r_count, n_count;

    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_cmd         = r_mem[r_rptr];

    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// File: hdl/tpc_back.sv
// Back end: ones'-complement accumulator, length counter, pseudo-header tail, output.
module tpc_back
    import tpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  t_tpc_cmd    i_cmd,
    input  t_tpc_qstat  i_qstat,
    output logic        o_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // checksum[15:0], segment_length[31:16]
);

    logic [7:0]  r_proto;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_count, n_count;
    logic        r_pseudo, n_pseudo;

    logic        r_e1_valid, n_e1_valid;
    logic [15:0] r_e1_acc, r_e1_tail, r_e1_count;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_data;

    logic        w_out_ready, w_e1_free, w_e1_move;
    logic [15:0] w_acc_base, w_cnt_base, w_acc_sum, w_cnt_inc;
    logic        w_pseudo_seg;

    assign w_out_ready = !r_out_valid || m_axis_tready;
    assign w_e1_free   = !r_e1_valid || w_out_ready;
    assign w_e1_move   = r_e1_valid && w_out_ready;
    assign o_pop       = !i_qstat.empty && (!i_cmd.last || w_e1_free);

    assign w_acc_base   = i_cmd.first ? i_cmd.addr_sum : r_acc;
    assign w_cnt_base   = i_cmd.first ? 16'd0 : r_count;
    assign w_pseudo_seg = i_cmd.first ? i_cmd.pseudo : r_pseudo;
    assign w_acc_sum    = oc_add(w_acc_base, i_cmd.word);
    assign w_cnt_inc    = (w_cnt_base == COUNT_MAX) ? COUNT_MAX : w_cnt_base + 16'd1;

    always_comb begin
        n_acc    = r_acc;
        n_count  = r_count;
        n_pseudo = r_pseudo;
        if (o_pop) begin
            if (i_cmd.last) begin
                n_acc    = 16'd0;
                n_count  = 16'd0;
                n_pseudo = 1'b0;
            end else begin
                n_acc    = w_acc_sum;
                n_count  = w_cnt_inc;
                n_pseudo = w_pseudo_seg;
            end
        end
    end

    always_comb begin
        n_e1_valid = r_e1_valid;
        if (o_pop && i_cmd.last) begin
            n_e1_valid = 1'b1;
        end else if (w_out_ready) begin
            n_e1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_e1_move) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proto     <= PROTO_TCP;
            r_acc       <= 16'd0;
            r_count     <= 16'd0;
            r_pseudo    <= 1'b0;
            r_e1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_proto <= i_cfg_wdata;
            end
            r_acc       <= n_acc;
            r_count     <= n_count;
            r_pseudo    <= n_pseudo;
            r_e1_valid  <= n_e1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.last) begin
            r_e1_acc   <= w_acc_sum;
            r_e1_count <= w_cnt_inc;
            r_e1_tail  <= w_pseudo_seg ? oc_add({8'h00, r_proto}, w_cnt_inc) : 16'd0;
        end
        if (w_e1_move) begin
            r_out_data <= {r_e1_count, ~oc_add(r_e1_acc, r_e1_tail)};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: hdl/tcp_pseudo_header_checksum.sv
// Top level of the byte-serial TCP / Internet checksum engine.
//
// Input stream (s_axis): one segment byte per request, in transmission order.
//   tdata carries the byte and the IPv4 source and destination addresses,
//   tuser carries the first-byte and use-pseudo-header flags, tlast ends the
//   segment. Addresses and use-pseudo are only looked at with the first byte.
// Output stream (m_axis): one request per segment, issued for the last byte,
//   carrying the inverted folded sum and the saturated byte count.
// Config: i_cfg_we / i_cfg_wdata write the protocol number (reset 6); the user
//   must see that it is written only while the engine is idle; the block does not enforce this.
//
// Throughput: one byte per cycle, sustained while m_axis accepts results. The
// accumulator adds one 16-bit word per cycle with end-around carry, and that loop
// sets the rate. After the last byte is accepted, the checksum reaches m_axis
// via the front register, a queue entry, the end-of-segment and output registers.
// Reset: synchronous, active low; clears the queue, all stage valids and the
// running sum, and restores the protocol number to 6.
// Stall: when m_axis_tready is low the result holds in the output register and
// a second one waits in the end-of-segment register; the accumulator keeps
// taking bytes until a third segment end reaches the queue head, then the
// 4-entry queue and front register fill and s_axis_tready drops.
module tcp_pseudo_header_checksum
    import tpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // data_byte[7:0], src_addr[39:8], dst_addr[71:40]
    input  logic        s_axis_tlast,   // last
    input  logic [1:0]  s_axis_tuser,   // first[0], use_pseudo[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // checksum[15:0], segment_length[31:16]
);

    logic       w_push, w_pop;
    t_tpc_cmd   w_push_cmd, w_head_cmd;
    t_tpc_qstat w_qstat;

    tpc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .i_qstat       (w_qstat),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    // decouples pairing from accumulation so either side can stall alone
    tpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_qstat (w_qstat)
    );

    tpc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (w_head_cmd),
        .i_qstat       (w_qstat),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("queue push while full");

    // no pop from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("queue pop while empty");

    // nothing is offered downstream right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule
